// File: hdl/mri_pkg.sv
package mri_pkg;

    localparam int FRAC_BITS  = 30;
    localparam int IG_FRAC    = 29;
    localparam int AREA_FRAC  = 40;
    localparam int TERM_SHIFT = FRAC_BITS + IG_FRAC - AREA_FRAC;

    localparam int IN_W   = 32;
    localparam int REG_W  = 31;
    localparam int POS_W  = 33;
    localparam int AREA_W = 44;
    localparam int PROD_W = 2 * IN_W;
    localparam int DEN_W  = PROD_W - FRAC_BITS + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int QUO_W  = 32;
    localparam int TPROD_W = QUO_W + REG_W;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam int UPC_W  = 4;

    localparam logic [AREA_W-1:0] AREA_MAX  = '1;
    localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(64'd4 << FRAC_BITS);
    localparam logic [DEN_W-1:0]  DEN_ONE   = DEN_W'(64'd1 << FRAC_BITS);
    // numerator is 4.0 scaled by 2^IG_FRAC; the bits above its low QUO_W bits seed the remainder
    localparam logic [REM_W-1:0]  REM_INIT  =
        REM_W'(64'd1 << (FRAC_BITS + 2 + IG_FRAC - QUO_W));
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(QUO_W - 1);

    localparam logic [REG_W-1:0] WIDTH_RESET = REG_W'(268435456);
    localparam logic [REG_W-1:0] STEP_RESET  = REG_W'(1048576);

    typedef enum logic {
        REG_INTERVAL_WIDTH,
        REG_STEP_SIZE
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_SQUARE,
        OP_DENOM,
        OP_DIV,
        OP_MUL,
        OP_ACC,
        OP_ADVANCE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_BAD_RANGE,
        COND_LOOP_END,
        COND_DIV_MORE,
        COND_AREA_OVF,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [UPC_W-1:0]  target;
    } ctrl_t;

    localparam logic [UPC_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] STEP_CHECK  = 4'd1;
    localparam logic [UPC_W-1:0] STEP_LOOP   = 4'd2;
    localparam logic [UPC_W-1:0] STEP_SQUARE = 4'd3;
    localparam logic [UPC_W-1:0] STEP_DENOM  = 4'd4;
    localparam logic [UPC_W-1:0] STEP_DIV    = 4'd5;
    localparam logic [UPC_W-1:0] STEP_MUL    = 4'd6;
    localparam logic [UPC_W-1:0] STEP_ACC    = 4'd7;
    localparam logic [UPC_W-1:0] STEP_ADV    = 4'd8;
    localparam logic [UPC_W-1:0] STEP_DONE   = 4'd9;
    localparam logic [UPC_W-1:0] STEP_RET    = 4'd10;

    // microprogram: on a true condition go to target, else fall through
    function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
        ctrl_t c;
        begin
            unique case (upc)
                STEP_IDLE:   c = '{OP_LOAD,    COND_NO_REQ,    STEP_IDLE};
                STEP_CHECK:  c = '{OP_CHECK,   COND_BAD_RANGE, STEP_DONE};
                STEP_LOOP:   c = '{OP_NONE,    COND_LOOP_END,  STEP_DONE};
                STEP_SQUARE: c = '{OP_SQUARE,  COND_NEVER,     STEP_IDLE};
                STEP_DENOM:  c = '{OP_DENOM,   COND_NEVER,     STEP_IDLE};
                STEP_DIV:    c = '{OP_DIV,     COND_DIV_MORE,  STEP_DIV};
                STEP_MUL:    c = '{OP_MUL,     COND_NEVER,     STEP_IDLE};
                STEP_ACC:    c = '{OP_ACC,     COND_AREA_OVF,  STEP_DONE};
                STEP_ADV:    c = '{OP_ADVANCE, COND_ALWAYS,    STEP_LOOP};
                STEP_DONE:   c = '{OP_EMIT,    COND_OUT_BUSY,  STEP_DONE};
                STEP_RET:    c = '{OP_NONE,    COND_ALWAYS,    STEP_IDLE};
                default:     c = '{OP_NONE,    COND_ALWAYS,    STEP_IDLE};
            endcase
            return c;
        end
    endfunction

endpackage

// File: hdl/midpoint_rule_integrator_top.sv
// Midpoint-rule integrator, f(x) = 4 / (x*x + 1), microcoded.
// A request is loaded and range-checked, then each midpoint runs the loop, square,
// denominator, bit-per-cycle divider, multiply, accumulate and advance steps;
// an out-of-range bound, a zero step or an area overflow goes straight to the result.
// A new request is taken only once the previous result has been emitted; output stalls hold it.
// rst_n is asynchronous active low: sequencer idles, output invalid, width and step reset.
module midpoint_rule_integrator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [mri_pkg::REG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mri_pkg::IN_W-1:0]    interval_start,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mri_pkg::AREA_W-1:0]  area,
    output logic                        overflow
);
    import mri_pkg::*;

    logic [UPC_W-1:0]   upc_reg, upc_next;
    logic [REG_W-1:0]   width_reg, width_next;
    logic [REG_W-1:0]   step_reg, step_next;
    logic               out_valid_reg, out_valid_next;

    logic [POS_W-1:0]   end_reg, end_next;
    logic [POS_W-1:0]   x_reg, x_next;
    logic [AREA_W-1:0]  area_reg, area_next;
    logic               sat_reg, sat_next;
    logic [PROD_W-1:0]  sq_reg, sq_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [AREA_W-1:0]  term_reg, term_next;
    logic [AREA_W-1:0]  out_area_reg, out_area_next;
    logic               out_ovf_reg, out_ovf_next;

    ctrl_t              ctrl;
    logic               in_take;
    logic               out_busy;
    logic               bad_range;
    logic               loop_end;
    logic               area_ovf;
    logic               jump;
    logic [REG_W-1:0]   half;
    logic [REG_W-1:0]   rest;
    logic [POS_W:0]     edge_pos;
    logic [REM_W-1:0]   rem_shift;
    logic               rem_ge;
    logic [TPROD_W-1:0] tprod;
    logic [AREA_W:0]    sum;

    assign ctrl      = ucode(upc_reg);
    assign in_stall  = (upc_reg != STEP_IDLE);
    assign in_take   = in_valid && (upc_reg == STEP_IDLE);
    assign out_busy  = out_valid_reg && out_stall;

    assign half      = step_reg >> 1;
    assign rest      = step_reg - half;
    assign bad_range = (end_reg > POS_LIMIT) || (step_reg == '0);
    // right edge of the rectangle around x
    assign edge_pos  = {1'b0, x_reg} + (POS_W+1)'(rest);
    assign loop_end  = edge_pos > {1'b0, end_reg};
    assign rem_shift = {rem_reg[REM_W-2:0], 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign tprod     = quo_reg * step_reg;
    assign sum       = {1'b0, area_reg} + {1'b0, term_reg};
    assign area_ovf  = sum[AREA_W];

    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_REQ:    jump = !in_valid;
            COND_BAD_RANGE: jump = bad_range;
            COND_LOOP_END:  jump = loop_end;
            COND_DIV_MORE:  jump = (cnt_reg != '0);
            COND_AREA_OVF:  jump = area_ovf;
            COND_OUT_BUSY:  jump = out_busy;
            default:        jump = 1'b1;
        endcase
        upc_next = jump ? ctrl.target : upc_reg + 1'b1;
    end

    always_comb
    begin
        width_next     = width_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        end_next       = end_reg;
        x_next         = x_reg;
        area_next      = area_reg;
        sat_next       = sat_reg;
        sq_next        = sq_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        term_next      = term_reg;
        out_area_next  = out_area_reg;
        out_ovf_next   = out_ovf_reg;

        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_INTERVAL_WIDTH: width_next = cfg_data;
                REG_STEP_SIZE:      step_next  = cfg_data;
                default:            width_next = width_reg;
            endcase
        end

        unique case (ctrl.op)
            OP_NONE: ;
            OP_LOAD:
            begin
                if (in_take) begin
                    end_next  = {1'b0, interval_start} + POS_W'(width_reg);
                    x_next    = {1'b0, interval_start} + POS_W'(half);
                    area_next = '0;
                end
            end
            OP_CHECK:   sat_next = bad_range;
            // x stays below 4.0 inside the loop, so its low word carries it
            OP_SQUARE:  sq_next = x_reg[IN_W-1:0] * x_reg[IN_W-1:0];
            OP_DENOM:
            begin
                den_next = DEN_W'(sq_reg >> FRAC_BITS) + DEN_ONE;
                rem_next = REM_INIT;
                quo_next = '0;
                cnt_next = DIV_LAST;
            end
            OP_DIV:
            begin
                rem_next = rem_ge ? rem_shift - {1'b0, den_reg} : rem_shift;
                quo_next = {quo_reg[QUO_W-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_MUL:     term_next = AREA_W'(tprod >> TERM_SHIFT);
            OP_ACC:
            begin
                if (area_ovf)
                    sat_next = 1'b1;
                else
                    area_next = sum[AREA_W-1:0];
            end
            OP_ADVANCE: x_next = x_reg + POS_W'(step_reg);
            OP_EMIT:
            begin
                if (!out_busy) begin
                    out_valid_next = 1'b1;
                    out_area_next  = sat_reg ? AREA_MAX : area_reg;
                    out_ovf_next   = sat_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            upc_reg       <= STEP_IDLE;
            width_reg     <= WIDTH_RESET;
            step_reg      <= STEP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            upc_reg       <= upc_next;
            width_reg     <= width_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg      <= end_next;
        x_reg        <= x_next;
        area_reg     <= area_next;
        sat_reg      <= sat_next;
        sq_reg       <= sq_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        term_reg     <= term_next;
        out_area_reg <= out_area_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid = out_valid_reg;
    assign area      = out_area_reg;
    assign overflow  = out_ovf_reg;

endmodule

// File: dv/integrator_checker.sv
`timescale 1ns / 1ps
module integrator_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [mri_pkg::REG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [mri_pkg::IN_W-1:0]    interval_start,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [mri_pkg::AREA_W-1:0]  area,
    input  logic                        overflow,
    output int unsigned                 mismatches,
    output int unsigned                 outstanding
);
    import mri_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic              overflow;
    } area_result_t;

    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] step_reg;
    area_result_t     expected_areas[$];
    int unsigned      fail_total = 0;
    int unsigned      pending_total = 0;

    assign mismatches  = fail_total;
    assign outstanding = pending_total;

    // Midpoint sum of 4/(x*x+1) over [a, a+w] with step h, truncating everywhere.
    function automatic area_result_t integrate_interval(input logic [IN_W-1:0] a,
                                                        input logic [REG_W-1:0] w,
                                                        input logic [REG_W-1:0] h);
        logic [POS_W-1:0]  x_pos;
        logic [POS_W-1:0]  x_end;
        logic [REG_W-1:0]  half;
        logic [REG_W-1:0]  rest;
        logic [65:0]       sq_full;
        logic [63:0]       den;
        logic [63:0]       f;
        logic [63:0]       term;
        logic [AREA_W:0]   sum;
        logic              sat;
        area_result_t      r;
        half  = h >> 1;
        rest  = h - half;
        x_end = POS_W'(a) + POS_W'(w);
        x_pos = POS_W'(a) + POS_W'(half);
        sum   = '0;
        sat   = 1'b0;
        if (x_end > POS_LIMIT || h == '0)
            sat = 1'b1;
        else
            while (!sat && (34'(x_pos) + 34'(rest) <= 34'(x_end))) begin
                sq_full = 66'(x_pos) * 66'(x_pos);
                den     = 64'(sq_full >> FRAC_BITS) + (64'd1 << FRAC_BITS);
                // 4.0 in Q.30 carried 29 quotient bits further
                f       = (64'd1 << (FRAC_BITS + 2 + IG_FRAC)) / den;
                term    = (f * 64'(h)) >> TERM_SHIFT;
                sum     = sum + term[AREA_W:0];
                if (sum > {1'b0, AREA_MAX})
                    sat = 1'b1;
                else
                    x_pos = x_pos + POS_W'(h);
            end
        r.area     = sat ? AREA_MAX : sum[AREA_W-1:0];
        r.overflow = sat;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (fail_total < REPORT_LIMIT)
            $display("checker: %s mismatch: expected %h, got %h", what, want, got);
        fail_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        area_result_t want;
        if (!rst_n)
        begin
            width_reg = WIDTH_RESET;
            step_reg  = STEP_RESET;
            expected_areas.delete();
            pending_total = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_areas.size() == 0)
                    flag_mismatch("unrequested result", '0, {19'd0, area, overflow});
                else
                begin
                    want = expected_areas.pop_front();
                    if (area !== want.area)
                        flag_mismatch("area", 64'(want.area), 64'(area));
                    if (overflow !== want.overflow)
                        flag_mismatch("overflow", 64'(want.overflow), 64'(overflow));
                end
            end
            if (in_valid && !in_stall)
                expected_areas.push_back(integrate_interval(interval_start, width_reg,
                                                            step_reg));
            if (cfg_we)
            begin
                if (cfg_index == REG_INTERVAL_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_STEP_SIZE)
                    step_reg = cfg_data;
            end
            pending_total = expected_areas.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mri_pkg::*;

    localparam longint unsigned REG_MAX      = (64'd1 << REG_W) - 1;
    localparam logic [REG_W-1:0] Q_ONE       = REG_W'(1 << FRAC_BITS);
    localparam int               RANDOM_ITEMS = 80;
    localparam int unsigned      CYCLE_LIMIT  = 4_000_000;
    localparam int               FLUSH_CYCLES = 600;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_CHOPPY,
        RX_HOLD,
        RX_LIGHT
    } rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [REG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [IN_W-1:0]     interval_start = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [AREA_W-1:0]   area;
    logic                overflow;

    int unsigned         mismatches;
    int unsigned         outstanding;
    int unsigned         cycle_count = 0;
    int unsigned         burst_left = 0;
    rx_mode_t            rx_mode = RX_FREE;
    int unsigned         rx_window = 0;

    midpoint_rule_integrator_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .interval_start (interval_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .area           (area),
        .overflow       (overflow)
    );

    integrator_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .interval_start (interval_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .area           (area),
        .overflow       (overflow),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: windows of free flow, choppy, solid and light stalling
    always @(negedge clk)
    begin
        if (rx_window == 0)
        begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
            rx_window <= $urandom_range(8, 96);
        end
        else
            rx_window <= rx_window - 1;
        case (rx_mode)
            RX_FREE:   out_stall <= 1'b0;
            RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
            RX_HOLD:   out_stall <= 1'b1;
            default:   out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [REG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait until every request has its result, then reprogram both registers
    task automatic set_interval(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        write_reg(REG_INTERVAL_WIDTH, w);
        write_reg(REG_STEP_SIZE, h);
    endtask

    task automatic send_request(input logic [IN_W-1:0] a);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid       <= 1'b1;
        interval_start <= a;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic pick_config(output logic [REG_W-1:0] w, output logic [REG_W-1:0] h);
        int unsigned     kind;
        int unsigned     k;
        longint unsigned hh;
        longint unsigned ww;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            hh = 0;
            ww = $urandom & REG_MAX;
        end
        else if (kind == 1)
        begin
            ww = $urandom & REG_MAX;
            hh = $urandom_range(1, 32'(REG_MAX));
        end
        else
        begin
            k  = (kind < 4) ? $urandom_range(25, 200) : $urandom_range(0, 24);
            hh = $urandom_range(1, 32'(REG_MAX / (k + 1)));
            ww = hh * k + $urandom_range(0, 32'(hh - 1));
        end
        // keep the midpoint count, floor(w/h), bounded
        if (hh != 0 && ww / hh > 200)
            hh = ww / 200 + 1;
        w = REG_W'(ww);
        h = REG_W'(hh);
    endtask

    function automatic logic [IN_W-1:0] pick_start(input logic [REG_W-1:0] w);
        longint unsigned top_a;
        top_a = (64'd1 << IN_W) - w;
        if (top_a > 64'hFFFF_FFFF)
            top_a = 64'hFFFF_FFFF;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return $urandom_range(0, 32'(top_a));
    endfunction

    initial
    begin
        logic [REG_W-1:0] w;
        logic [REG_W-1:0] h;
        int unsigned      sent;
        int unsigned      n;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: width 0.25, step 2^-10
        send_request('0);
        send_request(32'hF000_0000);     // bound lands exactly on 4.0
        send_request(32'hF000_0001);     // bound past four
        send_request(32'hFFFF_FFFF);

        set_interval(REG_W'(REG_MAX), REG_W'(REG_MAX));
        send_request('0);
        send_request(32'h8000_0001);
        send_request(32'h8000_0002);

        // minimum step and width, midpoint right at the top of the range
        set_interval(REG_W'(1), REG_W'(1));
        send_request('0);
        send_request(32'hFFFF_FFFE);
        send_request(32'hFFFF_FFFF);

        // zero step
        set_interval(Q_ONE, '0);
        send_request('0);
        send_request(32'h0000_0001);

        // interval narrower than one step
        set_interval('0, Q_ONE);
        send_request('0);
        send_request(32'h6000_0000);

        set_interval(Q_ONE, Q_ONE);
        send_request('0);
        set_interval(REG_W'(3), REG_W'(2));
        send_request(32'h5555_5555);

        // widest interval, largest achievable sum
        set_interval(REG_W'(REG_MAX), REG_W'(1 << 24));
        send_request('0);
        send_request(32'hAAAA_AAAA);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick_config(w, h);
            set_interval(w, h);
            n = $urandom_range(4, 14);
            repeat (n)
            begin
                send_request(pick_start(w));
                sent++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (FLUSH_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
